/* rtl/core/wtsg_pkg.sv */
// Shared types and constants of the wavetable sound generator.
package wtsg_pkg;

    localparam int WAVE_LENGTH = 32;
    localparam int WAVE_AW = 5;

    typedef enum logic [3:0] {
        REG_SELECT = 4'd0,
        REG_MASTER = 4'd1,
        REG_PER_LO = 4'd2,
        REG_PER_HI = 4'd3,
        REG_MODE   = 4'd4,
        REG_PAN    = 4'd5,
        REG_WAVE   = 4'd6,
        REG_NOISE  = 4'd7
    } reg_addr_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [4:0] ATTEN_LIMIT = 5'd29;

    function automatic logic [7:0] atten_lookup(input logic [4:0] r);
        logic [7:0] v;
        begin
            case (r)
                5'd0: v = 8'd255;
                5'd1: v = 8'd214;
                5'd2: v = 8'd180;
                5'd3: v = 8'd151;
                5'd4: v = 8'd127;
                5'd5: v = 8'd107;
                5'd6: v = 8'd90;
                5'd7: v = 8'd76;
                5'd8: v = 8'd64;
                5'd9: v = 8'd53;
                5'd10: v = 8'd45;
                5'd11: v = 8'd38;
                5'd12: v = 8'd32;
                5'd13: v = 8'd27;
                5'd14: v = 8'd22;
                5'd15: v = 8'd19;
                5'd16: v = 8'd16;
                5'd17: v = 8'd13;
                5'd18: v = 8'd11;
                5'd19: v = 8'd9;
                5'd20: v = 8'd8;
                5'd21: v = 8'd6;
                5'd22: v = 8'd5;
                5'd23: v = 8'd4;
                5'd24: v = 8'd4;
                5'd25: v = 8'd3;
                5'd26: v = 8'd2;
                5'd27: v = 8'd2;
                5'd28: v = 8'd2;
                5'd29: v = 8'd1;
                default: v = 8'd0;
            endcase
            return v;
        end
    endfunction

    // Attenuated output of one side; zero when the total attenuation is out of the table.
    function automatic logic [12:0] attenuate(input logic [4:0] level, input logic [3:0] master,
                                              input logic [4:0] vol, input logic [3:0] pan);
        logic [6:0] r;
        begin
            r = {2'b00, ~master, 1'b0} + {2'b00, ~vol} + {2'b00, ~pan, 1'b0};
            if (r > {2'b00, ATTEN_LIMIT})
            begin
                return 13'd0;
            end
            return level * atten_lookup(r[4:0]);
        end
    endfunction

endpackage

/* rtl/core/wtsg_ram.sv */
// Generic single-port RAM with registered read.
module wtsg_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/core/six_channel_wavetable_sound_generator.sv */
// Top level of the six-channel wavetable sound generator.
// Input items on s_axis: a register write or one generator tick. A write
// goes through the accept, the register update and wave memory access
// (ST_WRD) and the level reload (ST_WRL). A tick visits the channels one
// after another through one shared channel datapath and the single wave
// memory port, in states ST_CHA and ST_CHB for each channel, then in the
// mix state ST_MIX. s_axis_tready is low while an item is at work. A tick
// that changed anything produces one stereo sample on m_axis; it sits in
// the output register until taken, and the next item is not taken while
// that register is full.
// After reset the wave memory is cleared, all CHANNEL_COUNT*32 entries,
// with s_axis_tready low; configuration writes are taken meanwhile.
// cfg_we writes the channel enable mask (reset value all ones).
module six_channel_wavetable_sound_generator #(
    parameter int CHANNEL_COUNT = 6,
    parameter int NOISE_CHANNEL_FIRST = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // operation, reg_address[3:0], write_data[7:0], zero
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [31:0] m_axis_tdata,  // left_sample[15:0], right_sample[15:0]
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata
);
    import wtsg_pkg::*;

    localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int DEPTH = CHANNEL_COUNT * WAVE_LENGTH;
    localparam int MAW = $clog2(DEPTH);
    localparam int NF = NOISE_CHANNEL_FIRST;
    localparam int NN = (CHANNEL_COUNT > NF) ? CHANNEL_COUNT - NF : 1;
    localparam int NW = (NN > 1) ? $clog2(NN) : 1;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_WRD   = 7'b0000100,
        ST_WRL   = 7'b0001000,
        ST_CHA   = 7'b0010000,
        ST_CHB   = 7'b0100000,
        ST_MIX   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0]  mask_reg;
    logic [MAW-1:0] clr_reg;
    logic [CW-1:0] ch_reg;
    logic [3:0]  addr_reg;
    logic [7:0]  data_reg;
    logic [2:0]  sel_reg;
    logic [3:0]  mlv_reg, mrv_reg;
    logic [11:0] per_reg [CHANNEL_COUNT];
    logic        on_reg [CHANNEL_COUNT];
    logic        dw_reg [CHANNEL_COUNT];
    logic [4:0]  vol_reg [CHANNEL_COUNT];
    logic [3:0]  pl_reg [CHANNEL_COUNT];
    logic [3:0]  pr_reg [CHANNEL_COUNT];
    logic [4:0]  pos_reg [CHANNEL_COUNT];
    logic [11:0] cnt_reg [CHANNEL_COUNT];
    logic [12:0] al_reg [CHANNEL_COUNT];
    logic [12:0] ar_reg [CHANNEL_COUNT];
    logic        ne_reg [NN];
    logic [10:0] np_reg [NN];
    logic [10:0] nc_reg [NN];
    logic [17:0] lfsr_reg [NN];
    logic [4:0]  nl_reg [NN];
    logic        pend_reg;
    logic        ev_reg;
    logic [15:0] suml_reg, sumr_reg;
    logic        ovalid_reg;
    logic [31:0] odata_reg;

    logic           ram_we;
    logic [MAW-1:0] ram_addr;
    logic [4:0]     ram_wdata, ram_rdata;

    logic       sel_ok;
    logic [CW-1:0] sel_c;
    logic       sel_noise;
    logic [NW-1:0] ns_idx;
    logic       ch_noise;
    logic [NW-1:0] cs_idx;
    logic       last_ch;
    logic       fire;
    logic [4:0] rd_pos;
    logic [4:0] wr_level;

    wtsg_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_wave (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign sel_ok = ({1'b0, sel_reg} < 4'(CHANNEL_COUNT));
    assign sel_c = CW'(sel_reg);
    assign sel_noise = sel_ok && ({1'b0, sel_reg} >= 4'(NF));
    assign ns_idx = NW'(CW'(sel_reg) - CW'(NF));
    assign ch_noise = (32'(ch_reg) >= 32'(NF));
    assign cs_idx = NW'(ch_reg - CW'(NF));
    assign last_ch = (32'(ch_reg) == CHANNEL_COUNT - 1);
    assign fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;
    assign rd_pos = (on_reg[ch_reg] && !dw_reg[ch_reg]) ? pos_reg[ch_reg] + 5'd1
                                                         : pos_reg[ch_reg];
    assign wr_level = (addr_reg == REG_WAVE) ? data_reg[4:0] : ram_rdata;

    // Wave memory address and write control.
    always_comb
    begin
        ram_we = 1'b0;
        ram_wdata = data_reg[4:0];
        ram_addr = {MAW{1'b0}};
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_wdata = 5'd0;
                ram_addr = clr_reg;
            end
            ST_WRD:
            begin
                ram_addr = MAW'(sel_c * WAVE_LENGTH) + MAW'(pos_reg[sel_c]);
                ram_we = (addr_reg == REG_WAVE) && sel_ok;
            end
            ST_CHA:
            begin
                ram_addr = MAW'(ch_reg * WAVE_LENGTH) + MAW'(rd_pos);
            end
            default: ram_addr = {MAW{1'b0}};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (32'(clr_reg) == DEPTH - 1) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (fire)
                begin
                    state_next = (s_axis_tdata[0] == OP_TICK) ? ST_CHA : ST_WRD;
                end
            end
            ST_WRD: state_next = ST_WRL;
            ST_WRL: state_next = ST_IDLE;
            ST_CHA: state_next = ST_CHB;
            ST_CHB: state_next = last_ch ? ST_MIX : ST_CHA;
            ST_MIX: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            mask_reg <= 6'h3F;
            clr_reg <= '0;
            ch_reg <= '0;
            addr_reg <= '0;
            data_reg <= '0;
            sel_reg <= '0;
            mlv_reg <= '0;
            mrv_reg <= '0;
            pend_reg <= 1'b0;
            ev_reg <= 1'b0;
            suml_reg <= '0;
            sumr_reg <= '0;
            ovalid_reg <= 1'b0;
            odata_reg <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                per_reg[i] <= '0; on_reg[i] <= 1'b0; dw_reg[i] <= 1'b0;
                vol_reg[i] <= '0; pl_reg[i] <= '0; pr_reg[i] <= '0;
                pos_reg[i] <= '0; cnt_reg[i] <= '0; al_reg[i] <= '0; ar_reg[i] <= '0;
            end
            for (int i = 0; i < NN; i++)
            begin
                ne_reg[i] <= 1'b0; np_reg[i] <= '0; nc_reg[i] <= '0;
                lfsr_reg[i] <= 18'd1; nl_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
            if (ovalid_reg && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE:
                begin
                    if (fire)
                    begin
                        addr_reg <= s_axis_tdata[4:1];
                        data_reg <= s_axis_tdata[12:5];
                        ch_reg <= '0;
                        ev_reg <= 1'b0;
                        suml_reg <= '0;
                        sumr_reg <= '0;
                    end
                end
                ST_WRD:
                begin
                    if (addr_reg == REG_SELECT)
                    begin
                        sel_reg <= data_reg[2:0];
                    end
                    else if (sel_ok)
                    begin
                        case (addr_reg)
                            REG_MASTER:
                            begin
                                mlv_reg <= data_reg[7:4];
                                mrv_reg <= data_reg[3:0];
                            end
                            REG_PER_LO: per_reg[sel_c][7:0] <= data_reg;
                            REG_PER_HI: per_reg[sel_c][11:8] <= data_reg[3:0];
                            REG_MODE:
                            begin
                                on_reg[sel_c] <= data_reg[7];
                                dw_reg[sel_c] <= data_reg[6];
                                vol_reg[sel_c] <= data_reg[4:0];
                                if (!data_reg[7] && !data_reg[6])
                                begin
                                    pos_reg[sel_c] <= '0;
                                end
                            end
                            REG_PAN:
                            begin
                                pl_reg[sel_c] <= data_reg[7:4];
                                pr_reg[sel_c] <= data_reg[3:0];
                            end
                            REG_NOISE:
                            begin
                                if (sel_noise)
                                begin
                                    ne_reg[ns_idx] <= data_reg[7];
                                    np_reg[ns_idx] <= (data_reg[4:0] == 5'h1F) ? 11'd32 :
                                                      {~data_reg[4:0], 6'd0};
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WRL:
                begin
                    // Level reload after a mode write with both bits set or a wave write.
                    if (sel_ok && (((addr_reg == REG_MODE) && on_reg[sel_c] && dw_reg[sel_c])
                                   || (addr_reg == REG_WAVE)))
                    begin
                        pend_reg <= 1'b1;
                        al_reg[sel_c] <= attenuate(wr_level, mlv_reg, vol_reg[sel_c],
                                                   pl_reg[sel_c]);
                        ar_reg[sel_c] <= attenuate(wr_level, mrv_reg, vol_reg[sel_c],
                                                   pr_reg[sel_c]);
                        if ((addr_reg == REG_WAVE) && !on_reg[sel_c])
                        begin
                            pos_reg[sel_c] <= pos_reg[sel_c] + 5'd1;
                        end
                    end
                end
                ST_CHA:
                begin
                    if (ch_noise)
                    begin
                        if (nc_reg[cs_idx] != 11'd0)
                        begin
                            nc_reg[cs_idx] <= nc_reg[cs_idx] - 11'd1;
                        end
                        else
                        begin
                            nc_reg[cs_idx] <= np_reg[cs_idx];
                            nl_reg[cs_idx] <= lfsr_reg[cs_idx][0] ? 5'd31 : 5'd0;
                            lfsr_reg[cs_idx] <= {lfsr_reg[cs_idx][0] ^ lfsr_reg[cs_idx][1]
                                                 ^ lfsr_reg[cs_idx][11] ^ lfsr_reg[cs_idx][12]
                                                 ^ lfsr_reg[cs_idx][17],
                                                 lfsr_reg[cs_idx][17:1]};
                        end
                    end
                end
                ST_CHB:
                begin
                    if (cnt_reg[ch_reg] != 12'd0)
                    begin
                        cnt_reg[ch_reg] <= cnt_reg[ch_reg] - 12'd1;
                        if (mask_reg[ch_reg])
                        begin
                            suml_reg <= suml_reg + 16'(al_reg[ch_reg]);
                            sumr_reg <= sumr_reg + 16'(ar_reg[ch_reg]);
                        end
                    end
                    else
                    begin
                        logic [4:0] lv;
                        logic [12:0] nal, nar;
                        lv = 5'd0;
                        if (on_reg[ch_reg])
                        begin
                            if (ch_noise && ne_reg[cs_idx])
                            begin
                                lv = nl_reg[cs_idx];
                            end
                            else
                            begin
                                lv = ram_rdata;
                                if (!dw_reg[ch_reg])
                                begin
                                    pos_reg[ch_reg] <= pos_reg[ch_reg] + 5'd1;
                                end
                            end
                        end
                        nal = attenuate(lv, mlv_reg, vol_reg[ch_reg], pl_reg[ch_reg]);
                        nar = attenuate(lv, mrv_reg, vol_reg[ch_reg], pr_reg[ch_reg]);
                        cnt_reg[ch_reg] <= per_reg[ch_reg];
                        al_reg[ch_reg] <= nal;
                        ar_reg[ch_reg] <= nar;
                        ev_reg <= 1'b1;
                        if (mask_reg[ch_reg])
                        begin
                            suml_reg <= suml_reg + 16'(nal);
                            sumr_reg <= sumr_reg + 16'(nar);
                        end
                    end
                    ch_reg <= ch_reg + 1'b1;
                end
                ST_MIX:
                begin
                    if (pend_reg || ev_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        odata_reg <= {sumr_reg, suml_reg};
                    end
                    pend_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/wtsg_checker.sv */
// Port-level checker for the sound generator, bound to the top level.
module wtsg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled item changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Item accepted while busy.");

    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("Input ready while output full.");

    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("Output repeated.");

endmodule

bind six_channel_wavetable_sound_generator wtsg_checker u_wtsg_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
